@@ hw/rtl/gbt_pkg.sv @@
// Shared types and constants for the graph traversal block.
`default_nettype none

package gbt_pkg;

    localparam int VERTEX_W         = 6;
    localparam int CMD_W            = 2;
    localparam int VCOUNT_W         = 7;
    localparam int MAX_VERTICES_DEF = 64;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = '0;
    localparam logic [VCOUNT_W-1:0]  VCOUNT_RESET     = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_ADD_EDGE = 2'd1,
        CMD_BFS      = 2'd2,
        CMD_DFS      = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_A_RD,
        S_ADD_A_WR,
        S_ADD_B_RD,
        S_ADD_B_WR,
        S_FETCH,
        S_LOAD,
        S_ROW,
        S_EVAL,
        S_PUSH,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [VERTEX_W-1:0] vertex;
        logic                last;
        logic                err;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/gbt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module gbt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/gbt_regs.sv @@
// APB configuration register file: vertex count.
`default_nettype none

module gbt_regs
    import gbt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [VCOUNT_W-1:0]   vertex_count
);

    logic [VCOUNT_W-1:0]  vertex_count_reg;
    logic [VCOUNT_W-1:0]  vertex_count_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        vertex_count_next = vertex_count_reg;
        if (wr_en && (reg_idx == REG_VERTEX_COUNT))
        begin
            vertex_count_next = pwdata[VCOUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VCOUNT_RESET;
        end
        else
        begin
            vertex_count_reg <= vertex_count_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_VERTEX_COUNT)
        begin
            prdata = APB_DATA_W'(vertex_count_reg);
        end
    end

    assign vertex_count = vertex_count_reg;

endmodule

`default_nettype wire

@@ hw/rtl/graph_bfs_dfs_traversal.sv @@
// Graph traversal top level: adjacency store, BFS queue / DFS stack, sequencer.
//
// Usage: drive command, vertex_a, vertex_b and raise start; the word is taken
// at a clock edge where start is high and busy is low. Clear gives no result.
// Add edge keeps busy through a read-modify-write of both adjacency rows and
// gives no result unless an endpoint is out of range.
// BFS and DFS give one word per visited vertex on visited_vertex, marked by
// result_valid for one cycle; last_of_run flags the final word of a run.
// A start vertex or endpoint at or beyond vertex_count gives a single error
// word (range_error and last_of_run high) in the cycle after acceptance.
// Each step reads one adjacency row through the single read port: BFS passes
// S_FETCH, S_LOAD, S_ROW and S_EVAL per vertex plus S_PUSH per queued neighbor;
// DFS passes S_ROW and S_EVAL per descent, S_FETCH through S_EVAL per backtrack.
// Results lag the traversal by one vertex so the last one can be flagged.
// Reset clears the graph (row valid bits) at once; no clearing pass is needed.
// The receiver cannot stall; each result word is valid for exactly one cycle.
// The user must set vertex_count (APB byte address 0) only while idle; unenforced.
`default_nettype none

module graph_bfs_dfs_traversal
    import gbt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [VERTEX_W-1:0]   vertex_a,
    input  wire logic [VERTEX_W-1:0]   vertex_b,
    output logic                       result_valid,
    output logic      [VERTEX_W-1:0]   visited_vertex,
    output logic                       last_of_run,
    output logic                       range_error
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int PTR_W = IDX_W + 1;

    function automatic logic [IDX_W-1:0] lowest_set(input logic [MAX_VERTICES-1:0] x);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (x[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // configuration
    logic [VCOUNT_W-1:0]     vertex_count;
    logic [VCOUNT_W-1:0]     cnt;
    logic [MAX_VERTICES-1:0] live;

    // state
    state_t                  state_reg, state_next;
    logic [PTR_W-1:0]        head_reg, head_next;
    logic [PTR_W-1:0]        tail_reg, tail_next;
    logic [PTR_W-1:0]        tail_m1;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic [MAX_VERTICES-1:0] fresh_reg, fresh_next;
    logic [MAX_VERTICES-1:0] live_reg, live_next;
    logic [IDX_W-1:0]        u_reg, u_next;
    logic [IDX_W-1:0]        a_reg, a_next;
    logic [IDX_W-1:0]        b_reg, b_next;
    logic                    dfs_reg, dfs_next;
    logic [IDX_W-1:0]        held_reg, held_next;
    logic                    held_valid_reg, held_valid_next;
    result_t                 res_reg, res_next;

    // memory ports
    logic                    adj_we;
    logic [IDX_W-1:0]        adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [IDX_W-1:0]        adj_raddr;
    logic [MAX_VERTICES-1:0] adj_rdata;
    logic                    pend_we;
    logic [IDX_W-1:0]        pend_waddr;
    logic [IDX_W-1:0]        pend_wdata;
    logic [IDX_W-1:0]        pend_raddr;
    logic [IDX_W-1:0]        pend_rdata;

    // scratch
    logic                    prod;
    logic [IDX_W-1:0]        prod_v;
    logic [MAX_VERTICES-1:0] row_eff;
    logic [MAX_VERTICES-1:0] fresh;
    logic [IDX_W-1:0]        pick;
    logic                    a_ok;
    logic                    b_ok;
    logic [IDX_W-1:0]        a_idx;
    logic [IDX_W-1:0]        b_idx;
    result_t                 err_word;

    gbt_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .vertex_count (vertex_count)
    );

    gbt_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // BFS queue or DFS stack
    gbt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_VERTICES)
    ) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

    assign cnt = (vertex_count > VCOUNT_W'(MAX_VERTICES)) ? VCOUNT_W'(MAX_VERTICES)
                                                          : vertex_count;

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            live[i] = (VCOUNT_W'(i) < cnt);
        end
    end

    assign a_ok    = VCOUNT_W'(vertex_a) < cnt;
    assign b_ok    = VCOUNT_W'(vertex_b) < cnt;
    assign a_idx   = vertex_a[IDX_W-1:0];
    assign b_idx   = vertex_b[IDX_W-1:0];
    assign tail_m1 = tail_reg - PTR_W'(1);

    // rows never written since the last clear read as empty
    assign row_eff = row_valid_reg[u_reg] ? adj_rdata : '0;
    assign fresh   = row_eff & live_reg & ~visited_reg;

    assign err_word = '{valid: 1'b1, vertex: '0, last: 1'b1, err: 1'b1};

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        visited_next    = visited_reg;
        row_valid_next  = row_valid_reg;
        fresh_next      = fresh_reg;
        live_next       = live_reg;
        u_next          = u_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        dfs_next        = dfs_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        res_next        = '0;

        adj_we     = 1'b0;
        adj_waddr  = a_reg;
        adj_wdata  = '0;
        adj_raddr  = u_reg;
        pend_we    = 1'b0;
        pend_waddr = tail_reg[IDX_W-1:0];
        pend_wdata = '0;
        pend_raddr = dfs_reg ? tail_m1[IDX_W-1:0] : head_reg[IDX_W-1:0];

        prod   = 1'b0;
        prod_v = '0;
        pick   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd_t'(command)) inside
                        CMD_CLEAR:
                        begin
                            row_valid_next = '0;
                        end
                        CMD_ADD_EDGE:
                        begin
                            if (a_ok && b_ok)
                            begin
                                a_next     = a_idx;
                                b_next     = b_idx;
                                state_next = S_ADD_A_RD;
                            end
                            else
                            begin
                                res_next = err_word;
                            end
                        end
                        CMD_BFS, CMD_DFS:
                        begin
                            if (!a_ok)
                            begin
                                res_next = err_word;
                            end
                            else
                            begin
                                visited_next = MAX_VERTICES'(1) << a_idx;
                                head_next    = '0;
                                tail_next    = PTR_W'(1);
                                live_next    = live;
                                pend_we      = 1'b1;
                                pend_waddr   = '0;
                                pend_wdata   = a_idx;
                                dfs_next     = (cmd_t'(command) == CMD_DFS);
                                if (cmd_t'(command) == CMD_DFS)
                                begin
                                    // preorder: the start vertex is visited at once
                                    prod       = 1'b1;
                                    prod_v     = a_idx;
                                    u_next     = a_idx;
                                    state_next = S_ROW;
                                end
                                else
                                begin
                                    state_next = S_FETCH;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD_A_RD:
            begin
                adj_raddr  = a_reg;
                state_next = S_ADD_A_WR;
            end
            S_ADD_A_WR:
            begin
                adj_we            = 1'b1;
                adj_waddr         = a_reg;
                adj_wdata         = (row_valid_reg[a_reg] ? adj_rdata : '0)
                                    | (MAX_VERTICES'(1) << b_reg);
                row_valid_next[a_reg] = 1'b1;
                state_next        = S_ADD_B_RD;
            end
            S_ADD_B_RD:
            begin
                // row a write has landed, so a self loop reads its own update
                adj_raddr  = b_reg;
                state_next = S_ADD_B_WR;
            end
            S_ADD_B_WR:
            begin
                adj_we            = 1'b1;
                adj_waddr         = b_reg;
                adj_wdata         = (row_valid_reg[b_reg] ? adj_rdata : '0)
                                    | (MAX_VERTICES'(1) << a_reg);
                row_valid_next[b_reg] = 1'b1;
                state_next        = S_IDLE;
            end
            S_FETCH:
            begin
                if (!dfs_reg)
                begin
                    head_next = head_reg + PTR_W'(1);
                end
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                u_next     = pend_rdata;
                state_next = S_ROW;
            end
            S_ROW:
            begin
                adj_raddr  = u_reg;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (!dfs_reg)
                begin
                    prod       = 1'b1;
                    prod_v     = u_reg;
                    fresh_next = fresh;
                    if (fresh != '0)
                    begin
                        state_next = S_PUSH;
                    end
                    else if (head_reg == tail_reg)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
                else if (fresh != '0)
                begin
                    pick         = lowest_set(fresh);
                    pend_we      = 1'b1;
                    pend_wdata   = pick;
                    visited_next = visited_reg | (MAX_VERTICES'(1) << pick);
                    tail_next    = tail_reg + PTR_W'(1);
                    prod         = 1'b1;
                    prod_v       = pick;
                    u_next       = pick;
                    state_next   = S_ROW;
                end
                else
                begin
                    // no unvisited neighbor: pop and resume from the new top
                    tail_next  = tail_m1;
                    state_next = (tail_m1 == '0) ? S_FINISH : S_FETCH;
                end
            end
            S_PUSH:
            begin
                pick         = lowest_set(fresh_reg);
                pend_we      = 1'b1;
                pend_wdata   = pick;
                visited_next = visited_reg | (MAX_VERTICES'(1) << pick);
                tail_next    = tail_reg + PTR_W'(1);
                fresh_next   = fresh_reg & (fresh_reg - MAX_VERTICES'(1));
                if (fresh_next == '0)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FINISH:
            begin
                res_next        = '{valid: 1'b1, vertex: VERTEX_W'(held_reg),
                                    last: 1'b1, err: 1'b0};
                held_valid_next = 1'b0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // one-deep hold: a vertex goes out once the next one is known
        if (prod)
        begin
            if (held_valid_reg)
            begin
                res_next = '{valid: 1'b1, vertex: VERTEX_W'(held_reg),
                             last: 1'b0, err: 1'b0};
            end
            held_next       = prod_v;
            held_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            visited_reg    <= '0;
            row_valid_reg  <= '0;
            dfs_reg        <= 1'b0;
            held_valid_reg <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            visited_reg    <= visited_next;
            row_valid_reg  <= row_valid_next;
            dfs_reg        <= dfs_next;
            held_valid_reg <= held_valid_next;
            res_reg        <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fresh_reg <= fresh_next;
        live_reg  <= live_next;
        u_reg     <= u_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        held_reg  <= held_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign result_valid   = res_reg.valid;
    assign visited_vertex = res_reg.vertex;
    assign last_of_run    = res_reg.last;
    assign range_error    = res_reg.err;

    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |=> (result_valid && last_of_run))
        else $error("run end did not flag its last word");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && range_error) |-> last_of_run)
        else $error("range error word not marked last");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_of_run) |-> busy)
        else $error("non-final word emitted outside a run");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !dfs_reg && (state_reg != S_ADD_A_RD) && (state_reg != S_ADD_A_WR)
         && (state_reg != S_ADD_B_RD) && (state_reg != S_ADD_B_WR))
        |-> (head_reg <= tail_reg))
        else $error("BFS queue head passed tail");

endmodule

`default_nettype wire
